### design/cgd_pkg.sv
// Shared types and constants for the cloud-in-cell grid deposit block.
package cgd_pkg;

   // Field widths of the stream payloads
   localparam int POS_W  = 32;
   localparam int MASS_W = 16;
   localparam int IDX_W  = 15;
   localparam int SUM_W  = 48;
   localparam int FRAC_W = 16;

   // Shared multiplier operand width (33 x 33 unsigned)
   localparam int MUL_W = 33;

   // CSR address width and register indexes (word address paddr[4:2])
   localparam int CSR_ADDR_W = 5;
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
   localparam logic [2:0] REG_SCALE_X  = 3'd3;
   localparam logic [2:0] REG_SCALE_Y  = 3'd4;
   localparam logic [2:0] REG_SCALE_Z  = 3'd5;

   localparam logic [31:0] SCALE_RESET = 32'h0001_0000;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   typedef enum logic [1:0] {
      CMD_DEPOSIT    = 2'd0,
      CMD_READ       = 2'd1,
      CMD_READ_CLEAR = 2'd2,
      CMD_NOP        = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ_DONE,
      ST_AXIS,
      ST_WEIGHT,
      ST_CORNER_MUL,
      ST_CORNER_ACC
   } state_type;

   // Operand pair handed to the shared multiplier
   typedef struct packed {
      logic [MUL_W-1:0] op_a;
      logic [MUL_W-1:0] op_b;
   } mul_req_type;

endpackage

### design/cic_grid_deposit_top.sv
// Top level of the cloud-in-cell grid deposit block: CSRs, sequencer, grid memory.
//
//   channel | direction | payload
//   --------+-----------+--------------------------------------------------------
//   req_    | in        | tuser: command; tdata: pos_x, pos_y, pos_z, mass, cell_index
//   rsp_    | out       | tdata: cell_value; tuser: overflowed
//   csr_    | in (APB)  | origin_x/y/z, scale_x/y/z at byte addresses 0..20
//
// A deposit runs axis mapping, then weight products, then for each of 8 corners a product
// and memory read followed by a saturating add and write, all through one shared
// multiplier. Read and read-clear wait until the output register is free to respond;
// a NOP command is accepted and the block stays idle.
// After reset a clearing pass writes zero to every cell, with req_tready low;
// CSR writes are taken throughout.
// A stalled response sits in the output register; new transactions are still accepted
// and only a read waits for the register to free up.
module cic_grid_deposit_top #(
   parameter int GRID_SIDE = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [127:0]                    req_tdata,   // pos_x, pos_y, pos_z, mass, cell_index
   input  logic [1:0]                      req_tuser,   // command
   // response stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [47:0]                     rsp_tdata,   // cell_value
   output logic [0:0]                      rsp_tuser,   // overflowed
   // configuration
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cgd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int CELLS = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(GRID_SIDE);
   localparam int IXW   = ((AW > cgd_pkg::IDX_W) ? AW : cgd_pkg::IDX_W) + 1;
   localparam logic [31:0]   SIDE_MAX  = 32'(GRID_SIDE - 1);
   localparam logic [CW-1:0] CELL_MAX  = CW'(GRID_SIDE - 1);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] SIDE_A    = AW'(GRID_SIDE);

   // Weight 1-f (hi=0) or f (hi=1), Q1.16 held in 33 bits
   function automatic logic [cgd_pkg::MUL_W-1:0] weight(input logic [15:0] f,
                                                         input logic hi);
      logic [16:0] lo_w;
      lo_w = 17'h1_0000 - {1'b0, f};
      return hi ? {17'b0, f} : {16'b0, lo_w};
   endfunction

   // ---------------------------------------------------------------- CSRs
   logic [31:0] origin_ff [3];
   logic [31:0] scale_ff  [3];
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            origin_ff[i] <= '0;
            scale_ff[i]  <= cgd_pkg::SCALE_RESET;
         end
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            cgd_pkg::REG_ORIGIN_X: origin_ff[0] <= csr_pwdata;
            cgd_pkg::REG_ORIGIN_Y: origin_ff[1] <= csr_pwdata;
            cgd_pkg::REG_ORIGIN_Z: origin_ff[2] <= csr_pwdata;
            cgd_pkg::REG_SCALE_X:  scale_ff[0]  <= csr_pwdata;
            cgd_pkg::REG_SCALE_Y:  scale_ff[1]  <= csr_pwdata;
            cgd_pkg::REG_SCALE_Z:  scale_ff[2]  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         cgd_pkg::REG_ORIGIN_X: csr_prdata = origin_ff[0];
         cgd_pkg::REG_ORIGIN_Y: csr_prdata = origin_ff[1];
         cgd_pkg::REG_ORIGIN_Z: csr_prdata = origin_ff[2];
         cgd_pkg::REG_SCALE_X:  csr_prdata = scale_ff[0];
         cgd_pkg::REG_SCALE_Y:  csr_prdata = scale_ff[1];
         cgd_pkg::REG_SCALE_Z:  csr_prdata = scale_ff[2];
         default:               csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- state
   cgd_pkg::state_type state_ff, state_in;
   logic [2:0]         step_ff, step_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic               sat_ff, sat_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;
   logic               out_free;

   // latched request
   cgd_pkg::cmd_type             cmd_ff;
   logic [31:0]                  pos_ff [3];
   logic [cgd_pkg::MASS_W-1:0]   mass_ff;
   logic [cgd_pkg::IDX_W-1:0]    idx_ff;

   // per-axis results and weight products
   logic                         neg_ff;
   logic [CW-1:0]                lo_cell_ff [3];
   logic [CW-1:0]                hi_cell_ff [3];
   logic [15:0]                  frac_ff    [3];
   logic [cgd_pkg::MUL_W-1:0]    wxy_ff     [4];
   logic [cgd_pkg::MUL_W-1:0]    wzm_ff     [2];

   // multiplier and memory
   cgd_pkg::mul_req_type             mul_req;
   logic [2*cgd_pkg::MUL_W-1:0]      mul_ff;
   logic [cgd_pkg::SUM_W-1:0]        cell_mem [CELLS];
   logic [cgd_pkg::SUM_W-1:0]        rdata_ff;
   logic                             mem_we;
   logic [AW-1:0]                    mem_waddr;
   logic [AW-1:0]                    mem_raddr;
   logic [cgd_pkg::SUM_W-1:0]        mem_wdata;

   logic [cgd_pkg::SUM_W-1:0]        rsp_data_ff;
   logic                             rsp_ovf_ff;

   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_valid_ff | rsp_tready;

   // ---------------------------------------------------------------- axis mapping
   logic [31:0]        cur_pos, cur_org, cur_scale;
   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic               cur_neg;

   always_comb begin
      unique case (step_ff[1:0])
         2'd0: begin
            cur_pos = pos_ff[0]; cur_org = origin_ff[0]; cur_scale = scale_ff[0];
         end
         2'd1: begin
            cur_pos = pos_ff[1]; cur_org = origin_ff[1]; cur_scale = scale_ff[1];
         end
         default: begin
            cur_pos = pos_ff[2]; cur_org = origin_ff[2]; cur_scale = scale_ff[2];
         end
      endcase
   end

   // exact 33-bit difference; its magnitude always fits 32 bits
   assign diff    = $signed({cur_pos[31], cur_pos}) - $signed({cur_org[31], cur_org});
   assign cur_neg = diff[32];
   assign mag     = cur_neg ? (33'd0 - 33'(diff)) : 33'(diff);

   // floor of the Q32.32 product to base cell, clamped corners and fraction
   logic [31:0]   base_pos;
   logic          prod_sticky;
   logic [15:0]   frac_neg_t;
   logic [CW-1:0] map_lo, map_hi;
   logic [15:0]   map_frac;
   logic [1:0]    map_axis;

   assign base_pos    = mul_ff[63:32];
   assign prod_sticky = |mul_ff[15:0];
   assign frac_neg_t  = mul_ff[31:16] + {15'b0, prod_sticky};
   assign map_axis    = step_ff[1:0] - 2'd1;

   always_comb begin
      if (!neg_ff) begin
         map_frac = mul_ff[31:16];
         map_lo   = (base_pos > SIDE_MAX) ? CELL_MAX : base_pos[CW-1:0];
         map_hi   = (base_pos >= SIDE_MAX) ? CELL_MAX : base_pos[CW-1:0] + CW'(1);
      end else begin
         // negative side: base is -1 or below unless the product is zero
         map_frac = 16'd0 - frac_neg_t;
         map_lo   = '0;
         map_hi   = (mul_ff[63:0] == 64'd0) ? CW'(1) : '0;
      end
   end

   // ---------------------------------------------------------------- corner address / add
   logic [CW-1:0]              cx, cy, cz;
   logic [AW-1:0]              corner_addr;
   logic [64:0]                round_sum;
   logic [32:0]                corner_add;
   logic [48:0]                acc_sum;
   logic                       acc_sat;
   logic [AW-1:0]              read_addr;
   logic [IXW-1:0]             idx_wide;
   logic                       idx_ok;

   assign cx = step_ff[2] ? hi_cell_ff[0] : lo_cell_ff[0];
   assign cy = step_ff[1] ? hi_cell_ff[1] : lo_cell_ff[1];
   assign cz = step_ff[0] ? hi_cell_ff[2] : lo_cell_ff[2];
   assign corner_addr = (AW'(cx) * SIDE_A + AW'(cy)) * SIDE_A + AW'(cz);

   // Q8.56 -> Q8.24 round half up, then 48-bit saturating add
   assign round_sum  = {1'b0, mul_ff[63:0]} + 65'h0_8000_0000;
   assign corner_add = round_sum[64:32];
   assign acc_sum    = {1'b0, rdata_ff} + {16'b0, corner_add};
   assign acc_sat    = acc_sum[48];

   assign idx_wide  = IXW'(idx_ff);
   assign idx_ok    = idx_wide < IXW'(CELLS);
   assign read_addr = idx_wide[AW-1:0];

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         cgd_pkg::ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == LAST_CELL) begin
               state_in = cgd_pkg::ST_IDLE;
            end
         end
         cgd_pkg::ST_IDLE: begin
            step_in = '0;
            if (req_accept) begin
               unique case (cgd_pkg::cmd_type'(req_tuser))
                  cgd_pkg::CMD_DEPOSIT:    state_in = cgd_pkg::ST_AXIS;
                  cgd_pkg::CMD_READ:       state_in = cgd_pkg::ST_READ;
                  cgd_pkg::CMD_READ_CLEAR: state_in = cgd_pkg::ST_READ;
                  cgd_pkg::CMD_NOP:        state_in = cgd_pkg::ST_IDLE;
               endcase
            end
         end
         cgd_pkg::ST_READ: begin
            state_in = cgd_pkg::ST_READ_DONE;
         end
         cgd_pkg::ST_READ_DONE: begin
            if (out_free) begin
               state_in = cgd_pkg::ST_IDLE;
            end
         end
         cgd_pkg::ST_AXIS: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd3) begin
               step_in  = '0;
               state_in = cgd_pkg::ST_WEIGHT;
            end
         end
         cgd_pkg::ST_WEIGHT: begin
            step_in = step_ff + 3'd1;
            if (step_ff == 3'd6) begin
               step_in  = '0;
               state_in = cgd_pkg::ST_CORNER_MUL;
            end
         end
         cgd_pkg::ST_CORNER_MUL: begin
            state_in = cgd_pkg::ST_CORNER_ACC;
         end
         cgd_pkg::ST_CORNER_ACC: begin
            step_in  = step_ff + 3'd1;
            state_in = (step_ff == 3'd7) ? cgd_pkg::ST_IDLE : cgd_pkg::ST_CORNER_MUL;
         end
      endcase
   end

   // ---------------------------------------------------------------- outputs / datapath control
   always_comb begin
      req_tready     = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = corner_addr;
      mem_wdata      = '0;
      mem_raddr      = read_addr;
      mul_req.op_a   = {1'b0, mag[31:0]};
      mul_req.op_b   = {1'b0, cur_scale};
      sat_in         = sat_ff;
      rsp_valid_in   = rsp_valid_ff & ~rsp_tready;
      unique case (state_ff)
         cgd_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
         end
         cgd_pkg::ST_IDLE: begin
            req_tready = 1'b1;
         end
         cgd_pkg::ST_READ: ;
         cgd_pkg::ST_READ_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               mem_we       = (cmd_ff == cgd_pkg::CMD_READ_CLEAR) && idx_ok;
               mem_waddr    = read_addr;
            end
         end
         cgd_pkg::ST_AXIS: ;
         cgd_pkg::ST_WEIGHT: begin
            if (step_ff[2]) begin
               mul_req.op_a = weight(frac_ff[2], step_ff[0]);
               mul_req.op_b = {17'b0, mass_ff};
            end else begin
               mul_req.op_a = weight(frac_ff[0], step_ff[1]);
               mul_req.op_b = weight(frac_ff[1], step_ff[0]);
            end
         end
         cgd_pkg::ST_CORNER_MUL: begin
            mul_req.op_a = wxy_ff[step_ff[2:1]];
            mul_req.op_b = wzm_ff[step_ff[0]];
            mem_raddr    = corner_addr;
         end
         cgd_pkg::ST_CORNER_ACC: begin
            mem_we    = 1'b1;
            mem_wdata = acc_sat ? cgd_pkg::SUM_MAX : acc_sum[47:0];
            sat_in    = sat_ff | acc_sat;
         end
      endcase
   end

   // ---------------------------------------------------------------- control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cgd_pkg::ST_CLEAR;
         step_ff      <= '0;
         clr_ff       <= '0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- payload registers
   always_ff @(posedge clock) begin
      // latch the request transaction
      if (req_accept) begin
         cmd_ff    <= cgd_pkg::cmd_type'(req_tuser);
         pos_ff[0] <= req_tdata[31:0];
         pos_ff[1] <= req_tdata[63:32];
         pos_ff[2] <= req_tdata[95:64];
         mass_ff   <= req_tdata[111:96];
         idx_ff    <= req_tdata[126:112];
      end
      // axis: issue multiply for steps 0..2, map previous product for steps 1..3
      if (state_ff == cgd_pkg::ST_AXIS) begin
         if (step_ff != 3'd3) begin
            neg_ff <= cur_neg;
         end
         if (step_ff != 3'd0) begin
            lo_cell_ff[map_axis] <= map_lo;
            hi_cell_ff[map_axis] <= map_hi;
            frac_ff[map_axis]    <= map_frac;
         end
      end
      // weights: store the product issued at the previous step
      if (state_ff == cgd_pkg::ST_WEIGHT && step_ff != 3'd0) begin
         if (step_ff <= 3'd4) begin
            wxy_ff[2'(step_ff - 3'd1)] <= mul_ff[cgd_pkg::MUL_W-1:0];
         end else begin
            wzm_ff[~step_ff[0]] <= mul_ff[cgd_pkg::MUL_W-1:0];
         end
      end
      // response register
      if (state_ff == cgd_pkg::ST_READ_DONE && out_free) begin
         rsp_data_ff <= idx_ok ? rdata_ff : '0;
         rsp_ovf_ff  <= sat_ff;
      end
   end

   // ---------------------------------------------------------------- grid memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= cell_mem[mem_raddr];
   end

   cgd_mul_unit u_mul (
      .clock      (clock),
      .mul_req    (mul_req),
      .product_ff (mul_ff)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_ovf_ff;

endmodule

### design/cgd_mul_unit.sv
// Shared 33x33 unsigned multiplier with a registered product.
module cgd_mul_unit (
   input  logic                          clock,
   input  cgd_pkg::mul_req_type          mul_req,
   output logic [2*cgd_pkg::MUL_W-1:0]   product_ff
);

   logic [2*cgd_pkg::MUL_W-1:0] product_in;

   // Full-width product, operands zero extended
   assign product_in = {{cgd_pkg::MUL_W{1'b0}}, mul_req.op_a}
                     * {{cgd_pkg::MUL_W{1'b0}}, mul_req.op_b};

   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

endmodule

### design/cgd_checker.sv
// Port-level assertions for the grid deposit top level, with its bind.
module cgd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   logic ovf_seen_ff, ovf_seen_in;

   // remember an overflow report once it has been delivered
   assign ovf_seen_in = ovf_seen_ff | (rsp_tvalid & rsp_tready & rsp_tuser[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         ovf_seen_ff <= 1'b0;
      end else begin
         ovf_seen_ff <= ovf_seen_in;
      end
   end

   // stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // overflow flag is sticky across responses
   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ovf_seen_ff |-> rsp_tuser[0])
      else $error("overflow flag dropped after being reported");

   // clearing pass keeps requests out right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("request ready during grid clear");

   // a deposit or read keeps the block busy on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser != cgd_pkg::CMD_NOP) |=> !req_tready)
      else $error("request accepted while previous transaction in progress");

endmodule

bind cic_grid_deposit_top cgd_checker u_cgd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
